// ===== rtl/assert_macros.svh =====
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/bbbs_pkg.sv =====
// types and constants of the buffer based bitrate selector
package bbbs_pkg;

	localparam int NUM_REPS = 7;
	localparam logic [2:0] REP_LIMIT = 3'(NUM_REPS - 1);

	localparam logic [2:0] CFG_WINDOW_SPAN = 3'd0;
	localparam logic [2:0] CFG_GAIN_FACTOR = 3'd1;
	localparam logic [2:0] CFG_BUFFER_MIN  = 3'd2;
	localparam logic [2:0] CFG_BUFFER_LOW  = 3'd3;
	localparam logic [2:0] CFG_BUFFER_MAX  = 3'd4;
	localparam logic [2:0] CFG_TOP_REP     = 3'd5;

	localparam logic [31:0] RST_WINDOW_SPAN = 32'd655360;
	localparam logic [31:0] RST_GAIN_FACTOR = 32'd65536;
	localparam logic [31:0] RST_BUFFER_MIN  = 32'd131072;
	localparam logic [31:0] RST_BUFFER_LOW  = 32'd327680;
	localparam logic [31:0] RST_BUFFER_MAX  = 32'd1310720;
	localparam logic [2:0]  RST_TOP_REP     = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WIN,
		S_EVCHK,
		S_EVICT,
		S_RD1,
		S_RD2,
		S_AVG,
		S_MUL1,
		S_MUL2,
		S_DEC
	} state_t;

endpackage

// ===== rtl/bbbs_ram.sv =====
// generic single write port ram with registered read
module bbbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/buffer_based_bitrate_selector.sv =====
// top level of the buffer based bitrate selector
// One chunk event is taken at a time. A sample that fits the window passes from acceptance
// through S_WIN, S_RD1, S_RD2, S_AVG, S_MUL1, S_MUL2 and S_DEC back to S_IDLE; a sample
// that does not fit passes through S_EVCHK, and S_EVICT once per evicted sample, before
// S_RD1, since each eviction reads the oldest download time from the time memory and waits
// for its registered read. Smoothing reads the two newest throughputs from the flow memory
// one after the other, and one shared 32x32 multiplier forms the two gain products in
// S_MUL1 and S_MUL2. The result sits in an output register, so a new event is accepted
// while the previous result waits; a result that is not taken stalls only the final
// decision state. The sample memories need no clearing pass: only entries that hold samples are ever used.
`include "assert_macros.svh"
module buffer_based_bitrate_selector
	import bbbs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] chunk_down_time,
	input  logic [31:0] chunk_flow,
	input  logic [31:0] buffer_level,
	input  logic [2:0]  current_rep,
	input  logic [15:0] rep_use_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  next_rep,
	output logic [31:0] smoothed_flow,
	output logic [6:0]  window_entries,
	output logic        queue_overflow
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	state_t state_q, state_d;

	logic [31:0] window_span_q, gain_q, buf_min_q, buf_low_q, buf_max_q;
	logic [2:0]  top_rep_q;

	logic [31:0] down_q, flow_q, level_q;
	logic [2:0]  rep_q;
	logic [15:0] count_q;

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] fill_q;
	logic [31:0]      occ_q, avg_q, last_q;
	logic [63:0]      avg_prod_q, flow_prod_q;
	logic             ovf_q;

	logic [32:0]      sum_w;
	logic             over_w, full_w, push_w, dec_ok;
	logic [PTR_W-1:0] head_nx, tail_nx, tail_m1, tail_m2;
	logic [PTR_W-1:0] flow_raddr;
	logic [31:0]      time_rdata, flow_rdata;
	logic [31:0]      prev_w, avg_new;
	logic [33:0]      mix_w;
	logic [31:0]      mul_a;
	logic [63:0]      prod_w, count_w;
	logic [2:0]       rmax_w, next_w;
	logic [CNT_W+6:0] fill_ext;

	assign cfg_ready = 1'b1;

	// window arithmetic
	assign sum_w   = {1'b0, occ_q} + {1'b0, down_q};
	assign over_w  = sum_w > {1'b0, window_span_q};
	assign full_w  = fill_q == CNT_FULL;
	assign head_nx = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign tail_m1 = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;
	assign tail_m2 = (tail_m1 == '0) ? PTR_LAST : tail_m1 - 1'b1;

	// smoothing
	assign prev_w  = (fill_q > CNT_W'(1)) ? flow_rdata : last_q;
	assign mix_w   = {2'b00, prev_w} + {2'b00, last_q} + {1'b0, last_q, 1'b0};
	assign avg_new = (avg_q != '0) ? ((fill_q == '0) ? '0 : mix_w[33:2]) : flow_q;

	// shared multiplier
	assign prod_w = mul_a * gain_q;

	// representation choice
	assign count_w = {count_q, 32'd0};
	assign rmax_w  = (top_rep_q < REP_LIMIT) ? top_rep_q : REP_LIMIT;
	always_comb begin
		next_w = rep_q;
		if (level_q > buf_low_q && level_q < buf_max_q) begin
			if (avg_prod_q > count_w && rep_q < rmax_w) begin
				next_w = rep_q + 3'd1;
			end
		end else if (level_q > buf_min_q && level_q < buf_low_q) begin
			if (flow_prod_q < count_w && rep_q > 3'd0) begin
				next_w = rep_q - 3'd1;
			end else if (flow_prod_q > count_w && rep_q < rmax_w) begin
				next_w = rep_q + 3'd1;
			end
		end else if (level_q <= buf_min_q) begin
			next_w = 3'd0;
		end
	end

	assign dec_ok   = !out_valid || out_ready;
	assign fill_ext = {7'd0, fill_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_WIN;
			S_WIN:   state_d = over_w ? S_EVCHK : S_RD1;
			S_EVCHK: state_d = (over_w && fill_q != '0) ? S_EVICT : S_RD1;
			S_EVICT: state_d = S_EVCHK;
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_AVG;
			S_AVG:   state_d = S_MUL1;
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_DEC;
			S_DEC:   if (dec_ok) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		push_w     = 1'b0;
		flow_raddr = tail_m1;
		mul_a      = flow_q;
		case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_WIN:   push_w = !over_w && down_q != '0 && !full_w;
			S_RD2:   flow_raddr = tail_m2;
			S_MUL1:  mul_a = avg_q;
			default: ;
		endcase
	end

	bbbs_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (push_w),
		.waddr (tail_q),
		.wdata (down_q),
		.raddr (head_q),
		.rdata (time_rdata)
	);

	bbbs_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_flow_ram (
		.clk   (clk),
		.we    (push_w),
		.waddr (tail_q),
		.wdata (flow_q),
		.raddr (flow_raddr),
		.rdata (flow_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_span_q <= RST_WINDOW_SPAN;
			gain_q        <= RST_GAIN_FACTOR;
			buf_min_q     <= RST_BUFFER_MIN;
			buf_low_q     <= RST_BUFFER_LOW;
			buf_max_q     <= RST_BUFFER_MAX;
			top_rep_q     <= RST_TOP_REP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WINDOW_SPAN: window_span_q <= cfg_data;
				CFG_GAIN_FACTOR: gain_q <= cfg_data;
				CFG_BUFFER_MIN:  buf_min_q <= cfg_data;
				CFG_BUFFER_LOW:  buf_low_q <= cfg_data;
				CFG_BUFFER_MAX:  buf_max_q <= cfg_data;
				CFG_TOP_REP:     top_rep_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			occ_q     <= '0;
			avg_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_valid <= (state_q == S_DEC && dec_ok) || (out_valid && !out_ready);
			case (state_q)
				S_WIN: begin
					if (push_w) begin
						occ_q  <= sum_w[31:0];
						tail_q <= tail_nx;
						fill_q <= fill_q + 1'b1;
					end
				end
				S_EVICT: begin
					occ_q  <= (occ_q >= time_rdata) ? occ_q - time_rdata : '0;
					head_q <= head_nx;
					fill_q <= fill_q - 1'b1;
				end
				S_AVG: avg_q <= avg_new;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			down_q  <= chunk_down_time;
			flow_q  <= chunk_flow;
			level_q <= buffer_level;
			rep_q   <= current_rep;
			count_q <= rep_use_count;
		end
		case (state_q)
			S_WIN:  ovf_q <= !over_w && down_q != '0 && full_w;
			S_RD2:  last_q <= flow_rdata;
			S_MUL1: avg_prod_q <= prod_w;
			S_MUL2: flow_prod_q <= prod_w;
			S_DEC: begin
				if (dec_ok) begin
					next_rep       <= next_w;
					smoothed_flow  <= avg_q;
					window_entries <= fill_ext[6:0];
					queue_overflow <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	// queue bookkeeping check
	logic [SUM_W-1:0] hf_sum, hf_wrap;
	assign hf_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
	assign hf_wrap = (hf_sum >= SUM_W'(QUEUE_DEPTH)) ? hf_sum - SUM_W'(QUEUE_DEPTH) : hf_sum;

	`ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > CNT_FULL)
	`ASSERT_AT(a_ptr_consistent, clk, arst_n, hf_wrap == SUM_W'(tail_q))
	`ASSERT_NEVER(a_evict_nonempty, clk, arst_n, state_q == S_EVICT && fill_q == '0)
	`ASSERT_AT(a_accept_starts, clk, arst_n, in_valid && in_ready |=> state_q == S_WIN)
	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push_w && full_w)

endmodule
